// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file afm_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/afm_pkg.sv =====
// Types, codes and constants of the autoranging frequency meter.
// No dependencies; used by every module of the block.
package afm_pkg;

    localparam int MAX_EDGES  = 128;
    localparam int STAMP_W    = 16;
    localparam int CNT_W      = $clog2(MAX_EDGES + 1);
    localparam int SUM_W      = $clog2((MAX_EDGES - 2) * 65535 + 1);
    localparam int DIV_W      = 32;
    localparam int DIV_CNT_W  = $clog2(DIV_W);
    localparam int CFG_ADDR_W = 4;

    localparam logic [31:0] SLOW_TICK_RST = 32'd1440000;
    localparam logic [31:0] FAST_TICK_RST = 32'd18000000;
    localparam logic [15:0] SLOW_MIN_RST  = 16'd80;
    localparam logic [15:0] FAST_MIN_RST  = 16'd5;
    localparam logic [31:0] FREQ_ALL_ONES = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        OP_START   = 2'd0,
        OP_CAPTURE = 2'd1,
        OP_END     = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_VALID    = 2'd0,
        STAT_FEW      = 2'd1,
        STAT_TO_FAST  = 2'd2,
        STAT_FAST_OOR = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        REG_SLOW_TICK = 2'd0,
        REG_FAST_TICK = 2'd1,
        REG_SLOW_MIN  = 2'd2,
        REG_FAST_MIN  = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        FREQ_ZERO = 2'd0,
        FREQ_ONES = 2'd1,
        FREQ_QUOT = 2'd2
    } freq_sel_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SLOW,
        S_FAST,
        S_DONE,
        S_MEAN,
        S_CHECK,
        S_FREQ,
        S_EMIT
    } fsm_t;

    typedef struct packed {
        logic [31:0] slow_tick_hz;
        logic [31:0] fast_tick_hz;
        logic [15:0] slow_min_period;
        logic [15:0] fast_min_period;
    } cfg_t;

    typedef struct packed {
        logic      clear;
        logic      capture;
        logic      fast_sel;
        logic      div_mean;
        logic      div_freq;
        logic      mean_load;
        logic      load_out;
        status_t   out_status;
        freq_sel_t freq_sel;
        logic      out_fast;
    } dp_cmd_t;

    typedef struct packed {
        logic count_full;
        logic count_lt3;
        logic too_short;
        logic div_done;
        logic mean_zero;
        logic out_free;
    } dp_stat_t;

endpackage

// ===== sv/autorange_period_frequency_meter.sv =====
// Top level of the autoranging reciprocal frequency meter: register port and wiring.
// Depends on afm_pkg, afm_ctrl and afm_datapath.
//
//  channel   role       beat fields
//  s_        input      tuser: op; tdata: stamp
//  m_        result     tuser: status, fast_range; tdata: frequency
//  APB       config     slow/fast tick rates, slow/fast minimum periods
//
// Starts and captures are accepted back to back while no division runs.
// A window end that needs no division registers its result in the next cycle;
// otherwise the shared radix-2 divider finds the mean and then, unless the mean
// is zero, the frequency, with no beat accepted meanwhile.
// Reset is synchronous and active low; there is no clearing pass.
// Captures and starts are taken while a result waits; a window end waits for room.
module autorange_period_frequency_meter (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [15:0]                       s_tdata,   // [15:0] stamp
    input  logic [1:0]                        s_tuser,   // [1:0] op
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [31:0]                       m_tdata,   // [31:0] frequency
    output logic [2:0]                        m_tuser,   // [1:0] status, [2] fast_range
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [afm_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    logic [31:0]        slow_tick_reg, slow_tick_next;
    logic [31:0]        fast_tick_reg, fast_tick_next;
    logic [15:0]        slow_min_reg, slow_min_next;
    logic [15:0]        fast_min_reg, fast_min_next;
    logic               wr_en;
    afm_pkg::reg_idx_t  idx;
    afm_pkg::cfg_t      cfg;
    afm_pkg::dp_cmd_t   cmd;
    afm_pkg::dp_stat_t  stat;
    afm_pkg::status_t   out_status;
    logic [31:0]        out_freq;
    logic               out_fast;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = afm_pkg::reg_idx_t'(paddr[3:2]);

    always_comb begin
        slow_tick_next = slow_tick_reg;
        fast_tick_next = fast_tick_reg;
        slow_min_next  = slow_min_reg;
        fast_min_next  = fast_min_reg;
        if (wr_en) begin
            unique case (idx)
                afm_pkg::REG_SLOW_TICK: slow_tick_next = pwdata;
                afm_pkg::REG_FAST_TICK: fast_tick_next = pwdata;
                afm_pkg::REG_SLOW_MIN:  slow_min_next  = pwdata[15:0];
                afm_pkg::REG_FAST_MIN:  fast_min_next  = pwdata[15:0];
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            afm_pkg::REG_SLOW_TICK: prdata = slow_tick_reg;
            afm_pkg::REG_FAST_TICK: prdata = fast_tick_reg;
            afm_pkg::REG_SLOW_MIN:  prdata = {16'd0, slow_min_reg};
            afm_pkg::REG_FAST_MIN:  prdata = {16'd0, fast_min_reg};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slow_tick_reg <= afm_pkg::SLOW_TICK_RST;
            fast_tick_reg <= afm_pkg::FAST_TICK_RST;
            slow_min_reg  <= afm_pkg::SLOW_MIN_RST;
            fast_min_reg  <= afm_pkg::FAST_MIN_RST;
        end else begin
            slow_tick_reg <= slow_tick_next;
            fast_tick_reg <= fast_tick_next;
            slow_min_reg  <= slow_min_next;
            fast_min_reg  <= fast_min_next;
        end
    end

    assign cfg.slow_tick_hz    = slow_tick_reg;
    assign cfg.fast_tick_hz    = fast_tick_reg;
    assign cfg.slow_min_period = slow_min_reg;
    assign cfg.fast_min_period = fast_min_reg;

    afm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .op       (afm_pkg::op_t'(s_tuser)),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    afm_datapath u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .cmd        (cmd),
        .stat       (stat),
        .stamp      (s_tdata),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_status (out_status),
        .out_freq   (out_freq),
        .out_fast   (out_fast)
    );

    assign m_tdata = out_freq;
    assign m_tuser = {out_fast, out_status};

endmodule

// ===== sv/afm_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on afm_pkg for its width.
module afm_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [afm_pkg::DIV_W-1:0]  dividend,
    input  logic [afm_pkg::DIV_W-1:0]  divisor,
    output logic                       done,
    output logic [afm_pkg::DIV_W-1:0]  quotient
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [afm_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [afm_pkg::DIV_W-1:0]     rem_reg, rem_next;
    logic [afm_pkg::DIV_W-1:0]     quo_reg, quo_next;
    logic [afm_pkg::DIV_W-1:0]     dsr_reg, dsr_next;
    logic [afm_pkg::DIV_W:0]       rem_shift;
    logic [afm_pkg::DIV_W:0]       diff;
    logic                          fits;

    assign rem_shift = {rem_reg, quo_reg[afm_pkg::DIV_W-1]};
    assign diff      = rem_shift - {1'b0, dsr_reg};
    assign fits      = ~diff[afm_pkg::DIV_W];

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = afm_pkg::DIV_CNT_W'(afm_pkg::DIV_W - 1);
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            rem_next = fits ? diff[afm_pkg::DIV_W-1:0] : rem_shift[afm_pkg::DIV_W-1:0];
            quo_next = {quo_reg[afm_pkg::DIV_W-2:0], fits};
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== sv/afm_datapath.sv =====
// Datapath: period accumulation, mean and frequency division, result register.
// Depends on afm_pkg and afm_div.
module afm_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  afm_pkg::cfg_t                 cfg,
    input  afm_pkg::dp_cmd_t              cmd,
    output afm_pkg::dp_stat_t             stat,
    input  logic [afm_pkg::STAMP_W-1:0]   stamp,
    input  logic                          out_ready,
    output logic                          out_valid,
    output afm_pkg::status_t              out_status,
    output logic [31:0]                   out_freq,
    output logic                          out_fast
);

    logic [afm_pkg::CNT_W-1:0]   count_reg, count_next;
    logic [afm_pkg::STAMP_W-1:0] last_reg, last_next;
    logic [afm_pkg::SUM_W-1:0]   sum_reg, sum_next;
    logic                        short_reg, short_next;
    logic [afm_pkg::STAMP_W-1:0] mean_reg, mean_next;
    logic                        ovalid_reg, ovalid_next;
    afm_pkg::status_t            ostatus_reg, ostatus_next;
    logic [31:0]                 ofreq_reg, ofreq_next;
    logic                        ofast_reg, ofast_next;

    logic [afm_pkg::STAMP_W-1:0] period;
    logic [afm_pkg::STAMP_W-1:0] min_period;
    logic [afm_pkg::CNT_W-1:0]   periods;
    logic                        div_start;
    logic [afm_pkg::DIV_W-1:0]   div_a, div_b, div_q;
    logic                        div_done;
    logic [31:0]                 freq_val;

    assign period     = stamp - last_reg;
    assign min_period = cmd.fast_sel ? cfg.fast_min_period : cfg.slow_min_period;
    assign periods    = count_reg - afm_pkg::CNT_W'(2);

    assign div_start = cmd.div_mean | cmd.div_freq;
    assign div_a = cmd.div_mean
                 ? {{(afm_pkg::DIV_W - afm_pkg::SUM_W){1'b0}}, sum_reg}
                 : (cmd.fast_sel ? cfg.fast_tick_hz : cfg.slow_tick_hz);
    assign div_b = cmd.div_mean
                 ? {{(afm_pkg::DIV_W - afm_pkg::CNT_W){1'b0}}, periods}
                 : {{(afm_pkg::DIV_W - afm_pkg::STAMP_W){1'b0}}, mean_reg};

    afm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb begin
        unique case (cmd.freq_sel)
            afm_pkg::FREQ_ZERO: freq_val = '0;
            afm_pkg::FREQ_ONES: freq_val = afm_pkg::FREQ_ALL_ONES;
            afm_pkg::FREQ_QUOT: freq_val = div_q;
            default:            freq_val = '0;
        endcase
    end

    always_comb begin
        count_next   = count_reg;
        last_next    = last_reg;
        sum_next     = sum_reg;
        short_next   = short_reg;
        mean_next    = mean_reg;
        ostatus_next = ostatus_reg;
        ofreq_next   = ofreq_reg;
        ofast_next   = ofast_reg;
        ovalid_next  = ovalid_reg & ~out_ready;
        if (cmd.clear) begin
            count_next = '0;
            last_next  = '0;
            sum_next   = '0;
            short_next = 1'b0;
        end else if (cmd.capture) begin
            if (count_reg >= afm_pkg::CNT_W'(2)) begin
                sum_next = sum_reg + afm_pkg::SUM_W'(period);
                if (period < min_period) begin
                    short_next = 1'b1;
                end
            end
            last_next  = stamp;
            count_next = count_reg + 1'b1;
        end
        if (cmd.mean_load) begin
            mean_next = div_q[afm_pkg::STAMP_W-1:0];
        end
        if (cmd.load_out) begin
            ovalid_next  = 1'b1;
            ostatus_next = cmd.out_status;
            ofreq_next   = freq_val;
            ofast_next   = cmd.out_fast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            last_reg   <= '0;
            sum_reg    <= '0;
            short_reg  <= 1'b0;
            ovalid_reg <= 1'b0;
        end else begin
            count_reg  <= count_next;
            last_reg   <= last_next;
            sum_reg    <= sum_next;
            short_reg  <= short_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mean_reg    <= mean_next;
        ostatus_reg <= ostatus_next;
        ofreq_reg   <= ofreq_next;
        ofast_reg   <= ofast_next;
    end

    assign stat.count_full = count_reg >= afm_pkg::CNT_W'(afm_pkg::MAX_EDGES);
    assign stat.count_lt3  = count_reg < afm_pkg::CNT_W'(3);
    assign stat.too_short  = short_reg;
    assign stat.div_done   = div_done;
    assign stat.mean_zero  = mean_reg == '0;
    assign stat.out_free   = ~ovalid_reg | out_ready;

    assign out_valid  = ovalid_reg;
    assign out_status = ostatus_reg;
    assign out_freq   = ofreq_reg;
    assign out_fast   = ofast_reg;

endmodule

// ===== sv/afm_ctrl.sv =====
// Controller: window phase, range select and divider sequencing.
// Depends on afm_pkg; drives afm_datapath through its command struct.
module afm_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    input  afm_pkg::op_t       op,
    output logic               in_ready,
    input  afm_pkg::dp_stat_t  stat,
    output afm_pkg::dp_cmd_t   cmd
);

    afm_pkg::fsm_t state_reg, state_next;
    logic          fast_reg, fast_next;
    logic          rest;
    logic          window;
    logic          accept;

    assign rest = (state_reg == afm_pkg::S_IDLE) || (state_reg == afm_pkg::S_SLOW)
               || (state_reg == afm_pkg::S_FAST) || (state_reg == afm_pkg::S_DONE);
    assign window   = (state_reg == afm_pkg::S_SLOW) || (state_reg == afm_pkg::S_FAST);
    assign in_ready = rest && (stat.out_free || (op != afm_pkg::OP_END));
    assign accept   = in_valid && in_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            afm_pkg::S_IDLE, afm_pkg::S_DONE: begin
                if (accept && op == afm_pkg::OP_START) begin
                    state_next = afm_pkg::S_SLOW;
                end
            end
            afm_pkg::S_SLOW: begin
                if (accept && op == afm_pkg::OP_START) begin
                    state_next = afm_pkg::S_SLOW;
                end else if (accept && op == afm_pkg::OP_END) begin
                    priority if (stat.count_lt3) begin
                        state_next = afm_pkg::S_DONE;
                    end else if (stat.too_short) begin
                        state_next = afm_pkg::S_FAST;
                    end else begin
                        state_next = afm_pkg::S_MEAN;
                    end
                end
            end
            afm_pkg::S_FAST: begin
                if (accept && op == afm_pkg::OP_START) begin
                    state_next = afm_pkg::S_SLOW;
                end else if (accept && op == afm_pkg::OP_END) begin
                    state_next = (stat.count_lt3 || stat.too_short)
                               ? afm_pkg::S_DONE : afm_pkg::S_MEAN;
                end
            end
            afm_pkg::S_MEAN: begin
                if (stat.div_done) begin
                    state_next = afm_pkg::S_CHECK;
                end
            end
            afm_pkg::S_CHECK: begin
                state_next = stat.mean_zero ? afm_pkg::S_EMIT : afm_pkg::S_FREQ;
            end
            afm_pkg::S_FREQ: begin
                if (stat.div_done) begin
                    state_next = afm_pkg::S_EMIT;
                end
            end
            afm_pkg::S_EMIT: begin
                if (stat.out_free) begin
                    state_next = afm_pkg::S_DONE;
                end
            end
        endcase
    end

    always_comb begin
        cmd          = '0;
        cmd.fast_sel = fast_reg;
        fast_next    = fast_reg;
        unique case (state_reg)
            afm_pkg::S_IDLE, afm_pkg::S_DONE, afm_pkg::S_SLOW, afm_pkg::S_FAST: begin
                if (accept && op == afm_pkg::OP_START) begin
                    cmd.clear = 1'b1;
                    fast_next = 1'b0;
                end else if (accept && op == afm_pkg::OP_CAPTURE) begin
                    cmd.capture = window && !stat.count_full;
                end else if (accept && op == afm_pkg::OP_END
                             && state_reg == afm_pkg::S_SLOW) begin
                    priority if (stat.count_lt3) begin
                        cmd.load_out   = 1'b1;
                        cmd.out_status = afm_pkg::STAT_FEW;
                        cmd.freq_sel   = afm_pkg::FREQ_ZERO;
                        cmd.out_fast   = 1'b0;
                    end else if (stat.too_short) begin
                        cmd.clear      = 1'b1;
                        fast_next      = 1'b1;
                        cmd.load_out   = 1'b1;
                        cmd.out_status = afm_pkg::STAT_TO_FAST;
                        cmd.freq_sel   = afm_pkg::FREQ_ZERO;
                        cmd.out_fast   = 1'b1;
                    end else begin
                        cmd.div_mean = 1'b1;
                    end
                end else if (accept && op == afm_pkg::OP_END
                             && state_reg == afm_pkg::S_FAST) begin
                    if (stat.count_lt3 || stat.too_short) begin
                        cmd.load_out   = 1'b1;
                        cmd.out_status = afm_pkg::STAT_FAST_OOR;
                        cmd.freq_sel   = afm_pkg::FREQ_ONES;
                        cmd.out_fast   = 1'b1;
                    end else begin
                        cmd.div_mean = 1'b1;
                    end
                end
            end
            afm_pkg::S_MEAN: begin
                cmd.mean_load = stat.div_done;
            end
            afm_pkg::S_CHECK: begin
                cmd.div_freq = !stat.mean_zero;
            end
            afm_pkg::S_FREQ: begin
                cmd.div_freq = 1'b0;
            end
            afm_pkg::S_EMIT: begin
                cmd.load_out   = stat.out_free;
                cmd.out_status = afm_pkg::STAT_VALID;
                cmd.freq_sel   = stat.mean_zero ? afm_pkg::FREQ_ONES : afm_pkg::FREQ_QUOT;
                cmd.out_fast   = fast_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= afm_pkg::S_IDLE;
            fast_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            fast_reg  <= fast_next;
        end
    end

endmodule

// ===== sv/afm_checker.sv =====
// Port-level checks of the result channel, bound to the top level.
// Depends on afm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module afm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [2:0]  m_tuser
);

    `ASSERT_NEXT(a_valid_holds, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "result beat dropped while stalled")
    `ASSERT_NEXT(a_data_holds, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser), "stalled result beat changed")
    `ASSERT_IMPL(a_oor_ones, aclk, aresetn, m_tvalid && (m_tuser[1:0] == afm_pkg::STAT_FAST_OOR), (m_tdata == afm_pkg::FREQ_ALL_ONES) && m_tuser[2], "fast out of range without all ones")
    `ASSERT_IMPL(a_zero_freq, aclk, aresetn, m_tvalid && ((m_tuser[1:0] == afm_pkg::STAT_FEW) || (m_tuser[1:0] == afm_pkg::STAT_TO_FAST)), (m_tdata == 32'd0) && (m_tuser[2] == (m_tuser[1:0] == afm_pkg::STAT_TO_FAST)), "bad frequency or range on no-measurement beat")

endmodule

bind autorange_period_frequency_meter afm_checker u_afm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== verif/tb.sv =====
// Self-checking bench for autorange_period_frequency_meter: stream stimulus, APB set-up,
// a behavioural predictor of the meter and a result scoreboard.
// Depends on afm_pkg and the meter RTL only.
module tb;
    import afm_pkg::*;

    typedef enum logic [1:0] {MP_IDLE, MP_SLOW, MP_FAST, MP_DONE} meter_phase_e;

    typedef struct packed {
        status_t     status;
        logic [31:0] frequency;
        logic        fast_range;
    } report_t;

    typedef struct packed {
        op_t         op;
        logic [15:0] stamp;
        logic        typed;
        report_t     want;
    } script_row_t;

    localparam int          RAND_PER_SET = 92;
    localparam int          SETTINGS_N   = 6;
    localparam int          SETTLE_CYC   = 100;
    localparam report_t     NO_REPORT    = '{STAT_VALID, 32'd0, 1'b0};

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [15:0]           s_tdata;    // [15:0] stamp
    logic [1:0]            s_tuser;    // [1:0] op
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [31:0]           m_tdata;    // [31:0] frequency
    logic [2:0]            m_tuser;    // [1:0] status, [2] fast_range
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    autorange_period_frequency_meter dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // predictor copy of the meter
    logic [31:0]  cfg_slow_tick = SLOW_TICK_RST;
    logic [31:0]  cfg_fast_tick = FAST_TICK_RST;
    logic [15:0]  cfg_slow_min  = SLOW_MIN_RST;
    logic [15:0]  cfg_fast_min  = FAST_MIN_RST;
    meter_phase_e meter_phase   = MP_IDLE;
    logic         meter_fast    = 1'b0;
    int           edge_count    = 0;
    logic [15:0]  last_stamp    = '0;
    logic [31:0]  period_sum    = '0;
    logic         too_short     = 1'b0;

    report_t expected_reports[$];
    int      mismatches      = 0;
    int      reports_checked = 0;
    int      beats_sent      = 0;
    int      beats_effective = 0;
    int      burst_left      = 0;
    int      rx_mode         = 0;
    int      rx_left         = 0;

    script_row_t script [25] = '{
        '{OP_END,     16'h0000, 1'b0, NO_REPORT},
        '{OP_CAPTURE, 16'hFFFF, 1'b0, NO_REPORT},
        '{OP_NONE,    16'hA5A5, 1'b0, NO_REPORT},
        '{OP_START,   16'h0000, 1'b0, NO_REPORT},
        '{OP_CAPTURE, 16'h1234, 1'b0, NO_REPORT},
        '{OP_END,     16'h0000, 1'b1, '{STAT_FEW, 32'd0, 1'b0}},
        '{OP_CAPTURE, 16'h5A5A, 1'b0, NO_REPORT},
        '{OP_START,   16'hFFFF, 1'b0, NO_REPORT},
        '{OP_CAPTURE, 16'h0000, 1'b0, NO_REPORT},
        '{OP_CAPTURE, 16'hFFFF, 1'b0, NO_REPORT},
        '{OP_CAPTURE, 16'h00FF, 1'b0, NO_REPORT},
        '{OP_CAPTURE, 16'h01FF, 1'b0, NO_REPORT},
        '{OP_END,     16'hFFFF, 1'b1, '{STAT_VALID, 32'd5625, 1'b0}},
        '{OP_START,   16'h0000, 1'b0, NO_REPORT},
        '{OP_CAPTURE, 16'd100,  1'b0, NO_REPORT},
        '{OP_START,   16'h0000, 1'b0, NO_REPORT},
        '{OP_CAPTURE, 16'd100,  1'b0, NO_REPORT},
        '{OP_CAPTURE, 16'd200,  1'b0, NO_REPORT},
        '{OP_CAPTURE, 16'd210,  1'b0, NO_REPORT},
        '{OP_END,     16'h0000, 1'b1, '{STAT_TO_FAST, 32'd0, 1'b1}},
        '{OP_CAPTURE, 16'd0,    1'b0, NO_REPORT},
        '{OP_CAPTURE, 16'd10,   1'b0, NO_REPORT},
        '{OP_END,     16'h0000, 1'b1, '{STAT_FAST_OOR, FREQ_ALL_ONES, 1'b1}},
        '{OP_END,     16'h0000, 1'b0, NO_REPORT},
        '{OP_START,   16'h0000, 1'b0, NO_REPORT}
    };

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #4000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic void open_window(meter_phase_e ph);
        meter_phase = ph;
        edge_count  = 0;
        last_stamp  = '0;
        period_sum  = '0;
        too_short   = 1'b0;
    endfunction

    function automatic logic [31:0] tick_over_mean(logic [31:0] tick);
        logic [31:0] mean;
        mean = period_sum / 32'(edge_count - 2);
        return (mean == 0) ? FREQ_ALL_ONES : tick / mean;
    endfunction

    task automatic predict_report(input op_t op, input logic [15:0] stamp,
                                  output bit effective, output bit reported,
                                  output report_t rep);
        logic [15:0] period;
        logic [15:0] minp;
        effective = 1'b1;
        reported  = 1'b0;
        rep       = NO_REPORT;
        case (op)
            OP_START: begin
                meter_fast = 1'b0;
                open_window(MP_SLOW);
            end
            OP_CAPTURE: begin
                if (!(meter_phase == MP_SLOW || meter_phase == MP_FAST) ||
                    edge_count >= MAX_EDGES) begin
                    effective = 1'b0;
                end else begin
                    if (edge_count >= 2) begin
                        period = stamp - last_stamp;
                        minp   = (meter_phase == MP_FAST) ? cfg_fast_min : cfg_slow_min;
                        if (period < minp)
                            too_short = 1'b1;
                        period_sum += 32'(period);
                    end
                    last_stamp = stamp;
                    edge_count++;
                end
            end
            OP_END: begin
                if (meter_phase == MP_SLOW) begin
                    reported = 1'b1;
                    if (edge_count < 3) begin
                        meter_phase = MP_DONE;
                        rep = '{STAT_FEW, 32'd0, meter_fast};
                    end else if (too_short) begin
                        meter_fast = 1'b1;
                        open_window(MP_FAST);
                        rep = '{STAT_TO_FAST, 32'd0, 1'b1};
                    end else begin
                        rep = '{STAT_VALID, tick_over_mean(cfg_slow_tick), meter_fast};
                        meter_phase = MP_DONE;
                    end
                end else if (meter_phase == MP_FAST) begin
                    reported    = 1'b1;
                    meter_phase = MP_DONE;
                    if (edge_count < 3 || too_short)
                        rep = '{STAT_FAST_OOR, FREQ_ALL_ONES, meter_fast};
                    else
                        rep = '{STAT_VALID, tick_over_mean(cfg_fast_tick), meter_fast};
                end else begin
                    effective = 1'b0;
                end
            end
            default: effective = 1'b0;
        endcase
    endtask

    task automatic issue(input op_t op, input logic [15:0] stamp, input bit typed,
                         input report_t want, output bit effective);
        int      gap;
        bit      got;
        report_t rep;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= stamp;
        do @(posedge aclk); while (!s_tready);
        burst_left--;
        beats_sent++;
        predict_report(op, stamp, effective, got, rep);
        if (effective)
            beats_effective++;
        if (typed)
            expected_reports.push_back(want);
        else if (got)
            expected_reports.push_back(rep);
    endtask

    task automatic drain_reports();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        do @(posedge aclk); while (expected_reports.size() != 0);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {2'(idx), 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_SLOW_TICK: cfg_slow_tick = value;
            REG_FAST_TICK: cfg_fast_tick = value;
            REG_SLOW_MIN:  cfg_slow_min  = value[15:0];
            default:       cfg_fast_min  = value[15:0];
        endcase
        @(posedge aclk);
    endtask

    task automatic apply_setting(input int k);
        logic [31:0] st, ft, sm, fm;
        st = $urandom;
        ft = $urandom;
        sm = {16'($urandom), 16'($urandom_range(1, 300))};
        fm = {16'($urandom), 16'($urandom_range(1, 60))};
        case (k)
            1: begin st = 32'hFFFF_FFFF; ft = 32'hFFFF_FFFF; sm[15:0] = 16'hFFFF; fm[15:0] = 16'd1; end
            2: begin st = 32'd1; ft = 32'd1; sm[15:0] = 16'd1; fm[15:0] = 16'hFFFF; end
            3: begin sm[15:0] = 16'd0; fm[15:0] = 16'd0; end
            default: ;
        endcase
        write_reg(REG_SLOW_TICK, st);
        write_reg(REG_FAST_TICK, ft);
        write_reg(REG_SLOW_MIN, sm);
        write_reg(REG_FAST_MIN, fm);
    endtask

    // receiver: ready pattern switches among four random modes
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode <= $urandom_range(0, 3);
            rx_left <= $urandom_range(8, 64);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= ($urandom_range(0, 7) == 0);
            default: m_tready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    always @(posedge aclk) begin
        report_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_reports.size() == 0) begin
                $error("unexpected result beat: status %0d frequency %0h fast_range %0b",
                       m_tuser[1:0], m_tdata, m_tuser[2]);
                mismatches++;
            end else begin
                want = expected_reports.pop_front();
                reports_checked++;
                if (m_tuser[1:0] != want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_tuser[1:0]);
                    mismatches++;
                end
                if (m_tdata != want.frequency) begin
                    $error("frequency: expected %0d, got %0d", want.frequency, m_tdata);
                    mismatches++;
                end
                if (m_tuser[2] != want.fast_range) begin
                    $error("fast_range: expected %0b, got %0b", want.fast_range, m_tuser[2]);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        op_t          op;
        logic [15:0]  stamp;
        logic [15:0]  gen_stamp;
        logic [15:0]  minp;
        meter_phase_e plan_phase;
        int           plan_left;
        int           p_lo;
        int           p_hi;
        int           done_eff;
        int           r;
        bit           eff;

        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (script[i])
            issue(script[i].op, script[i].stamp, script[i].typed, script[i].want, eff);

        plan_phase = MP_IDLE;
        plan_left  = 0;
        gen_stamp  = '0;
        p_lo       = 0;
        p_hi       = 0;
        for (int k = 0; k < SETTINGS_N; k++) begin
            if (k != 0) begin
                drain_reports();
                repeat (SETTLE_CYC) @(posedge aclk);
                apply_setting(k);
            end
            done_eff = 0;
            while (done_eff < RAND_PER_SET) begin
                if ($urandom_range(0, 149) == 0)
                    drain_reports();
                if ($urandom_range(0, 9) == 0) begin
                    op    = op_t'($urandom_range(0, 3));
                    stamp = 16'($urandom);
                end else if (meter_phase == MP_IDLE || meter_phase == MP_DONE) begin
                    op    = OP_START;
                    stamp = 16'($urandom);
                end else begin
                    if (meter_phase != plan_phase) begin
                        // new window: edge count and period spread
                        plan_phase = meter_phase;
                        minp = (meter_phase == MP_FAST) ? cfg_fast_min : cfg_slow_min;
                        r = $urandom_range(0, 99);
                        if (r < 8)
                            plan_left = $urandom_range(0, 2);
                        else if (r < 11)
                            plan_left = $urandom_range(MAX_EDGES - 8, MAX_EDGES + 12);
                        else
                            plan_left = $urandom_range(3, 24);
                        case ($urandom_range(0, 3))
                            0: begin
                                p_lo = (minp > 3) ? minp - 3 : 0;
                                p_hi = (minp + 60 > 65535) ? 65535 : minp + 60;
                            end
                            1: begin p_lo = 0; p_hi = 65535; end
                            2: begin
                                p_lo = minp;
                                p_hi = (minp + 3000 > 65535) ? 65535 : minp + 3000;
                            end
                            default: begin p_lo = 0; p_hi = 1; end
                        endcase
                        gen_stamp = 16'($urandom);
                    end
                    if (plan_left > 0) begin
                        op        = OP_CAPTURE;
                        gen_stamp = gen_stamp + 16'($urandom_range(p_lo, p_hi));
                        stamp     = gen_stamp;
                        plan_left--;
                    end else begin
                        op         = OP_END;
                        stamp      = 16'($urandom);
                        plan_phase = MP_IDLE;
                    end
                end
                issue(op, stamp, 1'b0, NO_REPORT, eff);
                if (eff)
                    done_eff++;
            end
            // close any open window before the next register change
            while (meter_phase == MP_SLOW || meter_phase == MP_FAST)
                issue(OP_END, 16'($urandom), 1'b0, NO_REPORT, eff);
            plan_phase = MP_IDLE;
        end

        drain_reports();
        repeat (SETTLE_CYC) @(posedge aclk);
        $display("Run covered %0d input beats (%0d taking effect) over %0d register settings;",
                 beats_sent, beats_effective, SETTINGS_N);
        $display("%0d result beats were checked field by field.", reports_checked);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
